FILE: design/srtf_pkg.sv
// Package for the SRTF turnaround evaluator.
// Holds the sequencer state type and the field widths; no dependencies.
package srtf_pkg;

	localparam int MAX_JOBS_DEF = 1024;
	localparam int TIME_W       = 16;
	localparam int CLOCK_W      = 32;
	localparam int SUM_W        = 40;
	localparam int AVG_W        = 32;
	localparam int COUNT_W      = 11;
	localparam int DIVIDEND_W   = SUM_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} srtf_state_t;

endpackage

FILE: design/srtf_turnaround_evaluator.sv
// Top level of the SRTF turnaround evaluator: job memories, scheduling
// sequencer and restoring divider. Depends on srtf_pkg.
//
// Jobs load one per cycle while busy is low: a transaction is taken when start is high and
// busy is low. The transaction marked last_job starts the schedule; busy then stays high.
// Each scheduling step scans the stored jobs through one memory read port and then
// updates the chosen job; a set of N jobs takes at most about 2N + arrival gaps such
// steps. The average comes from a bit-serial divider.
// The result shows for exactly one cycle with result_valid and must be taken then.
module srtf_turnaround_evaluator
	import srtf_pkg::*;
#(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [TIME_W-1:0]    arrival_time,
	input  logic [TIME_W-1:0]    burst_length,
	input  logic                 last_job,
	output logic                 result_valid,
	output logic [AVG_W-1:0]     average_turnaround,
	output logic [SUM_W-1:0]     total_turnaround,
	output logic [COUNT_W-1:0]   job_count
);

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int DCW = $clog2(DIVIDEND_W + 1);

	srtf_state_t state_q, state_d;

	logic [TIME_W-1:0] arr_mem [MAX_JOBS];
	logic [TIME_W-1:0] rem_mem [MAX_JOBS];
	logic [TIME_W-1:0] arr_rd_s1, rem_rd_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic              rd_valid_s1;
	logic              rd_last_s1;

	logic [CW-1:0]     loaded_q;
	logic [CW-1:0]     left_q;
	logic [IW-1:0]     scan_q;
	logic              scan_on_q;
	logic [CLOCK_W-1:0] now_q;
	logic [SUM_W-1:0]  sum_q;

	logic              run_valid_q;
	logic [IW-1:0]     run_job_q;
	logic [TIME_W-1:0] run_rem_q;
	logic [TIME_W-1:0] run_arr_q;

	logic              have_q;
	logic [TIME_W:0]   best_q;
	logic [IW-1:0]     cand_q;
	logic [TIME_W-1:0] cand_arr_q;
	logic              has_next_q;
	logic [TIME_W-1:0] next_q;

	logic [DIVIDEND_W-1:0] quo_q;
	logic [CW:0]           part_q;
	logic [DCW-1:0]        div_cnt_q;

	logic accept, room, load_we, upd_we;
	logic [TIME_W-1:0] burst_fix;
	logic [CW-1:0] count_new;
	logic [CLOCK_W-1:0] gap, run_len, now_new;
	logic [TIME_W-1:0] rem_new;
	logic [SUM_W-1:0] sum_new;
	logic [CW:0] part_shift;
	logic last_scan;

	assign accept    = start && !busy;
	assign room      = loaded_q < CW'(MAX_JOBS);
	assign load_we   = accept && room;
	assign burst_fix = (burst_length == '0) ? TIME_W'(1) : burst_length;
	assign count_new = loaded_q + (room ? CW'(1) : CW'(0));
	assign last_scan = rd_valid_s1 && rd_last_s1;

	assign gap     = CLOCK_W'(next_q) - now_q;
	assign run_len = (has_next_q && gap < CLOCK_W'(best_q)) ? gap : CLOCK_W'(best_q);
	assign now_new = now_q + run_len;
	assign rem_new = TIME_W'(CLOCK_W'(best_q) - run_len);
	assign sum_new = sum_q + SUM_W'(now_new - CLOCK_W'(cand_arr_q));
	assign upd_we  = (state_q == ST_UPDATE) && have_q;

	assign part_shift = {part_q[CW-1:0], quo_q[DIVIDEND_W-1]};

	always_ff @(posedge clk) begin
		if (load_we) begin
			arr_mem[loaded_q[IW-1:0]] <= arrival_time;
		end
		arr_rd_s1 <= arr_mem[scan_q];
		rd_idx_s1 <= scan_q;
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			rem_mem[loaded_q[IW-1:0]] <= burst_fix;
		end else if (upd_we) begin
			rem_mem[cand_q] <= rem_new;
		end
		rem_rd_s1 <= rem_mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last_job) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_scan) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!have_q) begin
					state_d = has_next_q ? ST_SCAN : ST_DIVIDE;
				end else if (rem_new == '0 && left_q == CW'(1)) begin
					state_d = ST_DIVIDE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_DIVIDE: begin
				if (div_cnt_q == DCW'(DIVIDEND_W - 1)) state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			left_q      <= '0;
			scan_q      <= '0;
			scan_on_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			now_q       <= '0;
			sum_q       <= '0;
			run_valid_q <= 1'b0;
			run_job_q   <= '0;
			div_cnt_q   <= '0;
		end else begin
			rd_valid_s1 <= scan_on_q;
			rd_last_s1  <= scan_on_q && (CW'(scan_q) == loaded_q - CW'(1));
			if (scan_on_q) begin
				if (CW'(scan_q) == loaded_q - CW'(1)) begin
					scan_on_q <= 1'b0;
				end else begin
					scan_q <= scan_q + IW'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						loaded_q <= count_new;
						if (last_job) begin
							left_q      <= count_new;
							now_q       <= '0;
							sum_q       <= '0;
							run_valid_q <= 1'b0;
							run_job_q   <= '0;
							scan_q      <= '0;
							scan_on_q   <= 1'b1;
						end
					end
				end
				ST_UPDATE: begin
					scan_q    <= '0;
					scan_on_q <= 1'b1;
					if (!have_q) begin
						run_valid_q <= 1'b0;
						now_q       <= CLOCK_W'(next_q);
						if (!has_next_q) scan_on_q <= 1'b0;
					end else begin
						now_q <= now_new;
						if (rem_new == '0) begin
							sum_q       <= sum_new;
							left_q      <= left_q - CW'(1);
							run_valid_q <= 1'b0;
							if (left_q == CW'(1)) scan_on_q <= 1'b0;
						end else begin
							run_valid_q <= 1'b1;
							run_job_q   <= cand_q;
						end
					end
					div_cnt_q <= '0;
				end
				ST_DIVIDE: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
				end
				ST_DONE: begin
					loaded_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && have_q && rem_new != '0) begin
			run_rem_q <= rem_new;
			run_arr_q <= cand_arr_q;
		end
		if (state_q != ST_SCAN || !rd_valid_s1) begin
			have_q     <= run_valid_q;
			best_q     <= run_valid_q ? {1'b0, run_rem_q} : {1'b1, TIME_W'(0)};
			cand_q     <= run_job_q;
			cand_arr_q <= run_arr_q;
			has_next_q <= 1'b0;
			next_q     <= '0;
		end else if (rem_rd_s1 != '0) begin
			if (CLOCK_W'(arr_rd_s1) <= now_q) begin
				if ({1'b0, rem_rd_s1} < best_q) begin
					have_q     <= 1'b1;
					best_q     <= {1'b0, rem_rd_s1};
					cand_q     <= rd_idx_s1;
					cand_arr_q <= arr_rd_s1;
				end
			end else if (!has_next_q || arr_rd_s1 < next_q) begin
				has_next_q <= 1'b1;
				next_q     <= arr_rd_s1;
			end
		end
		if (state_q == ST_UPDATE) begin
			quo_q  <= DIVIDEND_W'((have_q && rem_new == '0) ? sum_new : sum_q) +
				DIVIDEND_W'(loaded_q >> 1);
			part_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			if (part_shift >= {1'b0, loaded_q}) begin
				part_q <= part_shift - {1'b0, loaded_q};
				quo_q  <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				part_q <= part_shift;
				quo_q  <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign busy               = (state_q != ST_IDLE);
	assign result_valid       = (state_q == ST_DONE);
	assign average_turnaround = quo_q[AVG_W-1:0];
	assign total_turnaround   = sum_q;
	assign job_count          = COUNT_W'(loaded_q);

endmodule

FILE: design/srtf_chk.sv
// Port-level checker for the SRTF turnaround evaluator, bound to the top level.
// Depends on srtf_pkg for field widths.
module srtf_chk
	import srtf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               last_job,
	input logic               result_valid,
	input logic [COUNT_W-1:0] job_count
);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe held");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result while idle");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_job |=> busy) else $error("last transaction not run");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_job |=> !busy && !result_valid)
		else $error("load transaction went busy");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> job_count != '0) else $error("empty job count");

endmodule

bind srtf_turnaround_evaluator srtf_chk u_srtf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_job     (last_job),
	.result_valid (result_valid),
	.job_count    (job_count)
);

FILE: test/tb_srtf_turnaround_evaluator.sv
// Testbench for srtf_turnaround_evaluator: loads job sets, predicts the SRTF
// turnaround result per set and checks each result transaction.
// Depends on srtf_pkg and the design top level.
`timescale 1ns / 100ps

module tb_srtf_turnaround_evaluator;
	import srtf_pkg::*;

	localparam int JOB_CAP = MAX_JOBS_DEF;
	localparam int IDLE_LIMIT = 3000000;

	typedef struct {
		logic [AVG_W-1:0]   avg;
		logic [SUM_W-1:0]   total;
		logic [COUNT_W-1:0] count;
	} turnaround_t;

	class srtf_scoreboard;
		int unsigned arrivals[$];
		int unsigned remaining[$];
		turnaround_t pending[$];
		int errors = 0;

		function void schedule_set();
			int unsigned n, left, cand, best, nxt, run, i;
			longint unsigned now;
			bit have, has_next, run_ok;
			int unsigned run_job;
			logic [SUM_W-1:0] sum;
			turnaround_t r;
			n = arrivals.size();
			left = n;
			now = 0;
			run_ok = 0;
			run_job = 0;
			sum = '0;
			while (left > 0) begin
				have = 0;
				best = 32'h10000;
				cand = 0;
				if (run_ok && remaining[run_job] > 0) begin
					cand = run_job;
					best = remaining[run_job];
					have = 1;
				end
				for (i = 0; i < n; i++)
					if (remaining[i] > 0 && arrivals[i] <= now && remaining[i] < best) begin
						cand = i;
						best = remaining[i];
						have = 1;
					end
				has_next = 0;
				nxt = 0;
				for (i = 0; i < n; i++)
					if (remaining[i] > 0 && arrivals[i] > now && (!has_next || arrivals[i] < nxt)) begin
						nxt = arrivals[i];
						has_next = 1;
					end
				if (!have) begin
					run_ok = 0;
					if (!has_next)
						break;
					now = nxt;
					continue;
				end
				run = best;
				if (has_next && nxt - now < run)
					run = nxt - now;
				now += run;
				remaining[cand] = best - run;
				if (remaining[cand] == 0) begin
					sum = sum + SUM_W'(now - arrivals[cand]);
					left--;
					run_ok = 0;
				end else begin
					run_job = cand;
					run_ok = 1;
				end
			end
			r.total = sum;
			r.count = COUNT_W'(n);
			r.avg = AVG_W'((DIVIDEND_W'(sum) + DIVIDEND_W'(n / 2)) / DIVIDEND_W'(n));
			pending.push_back(r);
			arrivals.delete();
			remaining.delete();
		endfunction

		function void note_job(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] burst, logic last);
			if (arrivals.size() < JOB_CAP) begin
				arrivals.push_back(arr);
				remaining.push_back(burst == 0 ? 1 : burst);
			end
			if (last)
				schedule_set();
		endfunction

		function void check_result(turnaround_t got);
			turnaround_t exp_r;
			if (pending.size() == 0) begin
				$error("result with no set pending: total %0d", got.total);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.avg !== exp_r.avg) begin
				$error("average_turnaround: expected %0d, got %0d", exp_r.avg, got.avg);
				errors++;
			end
			if (got.total !== exp_r.total) begin
				$error("total_turnaround: expected %0d, got %0d", exp_r.total, got.total);
				errors++;
			end
			if (got.count !== exp_r.count) begin
				$error("job_count: expected %0d, got %0d", exp_r.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [TIME_W-1:0] arrival_time = '0;
	logic [TIME_W-1:0] burst_length = '0;
	logic last_job = 0;
	logic result_valid;
	logic [AVG_W-1:0] average_turnaround;
	logic [SUM_W-1:0] total_turnaround;
	logic [COUNT_W-1:0] job_count;

	srtf_scoreboard sb = new();
	int idle_pct = 0;
	int idle_cycles = 0;
	int jobs_sent = 0;

	srtf_turnaround_evaluator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.arrival_time(arrival_time), .burst_length(burst_length), .last_job(last_job),
		.result_valid(result_valid), .average_turnaround(average_turnaround),
		.total_turnaround(total_turnaround), .job_count(job_count)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		turnaround_t got;
		if (result_valid) begin
			got.avg = average_turnaround;
			got.total = total_turnaround;
			got.count = job_count;
			sb.check_result(got);
		end
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_job(int unsigned arr, int unsigned burst, bit last);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		arrival_time <= TIME_W'(arr);
		burst_length <= TIME_W'(burst);
		last_job <= last;
		do @(posedge clk); while (busy);
		sb.note_job(TIME_W'(arr), TIME_W'(burst), last);
		jobs_sent++;
	endtask

	task automatic drop_start();
		start <= 0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned arr, size, burst, pick;
		int wait_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single short job, then the largest values
		send_job(0, 1, 1);
		send_job(16'hFFFF, 16'hFFFF, 1);
		// half-up rounding
		send_job(0, 1, 0);
		send_job(0, 1, 1);
		// preemption, equal-remaining ties, idle jump
		send_job(0, 10, 0);
		send_job(2, 3, 0);
		send_job(2, 3, 0);
		send_job(3, 9, 0);
		send_job(40, 5, 0);
		send_job(41, 4, 1);
		// no preemption on equal remaining time, then preemption by a job with one less
		send_job(0, 5, 0);
		send_job(1, 4, 0);
		send_job(16'h8000, 16'h5555, 0);
		send_job(16'hAAAA, 16'h2AAA, 1);
		// overflow: jobs beyond capacity are dropped, the last still starts the set
		for (int i = 0; i < JOB_CAP + 1; i++)
			send_job(0, $urandom_range(4, 1), i == JOB_CAP);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 63 : (phase == 3) ? 9 : 0;
			for (int done = 0; done < 100; done += size) begin
				size = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				pick = $urandom_range(3, 0);
				arr = (pick == 0) ? $urandom_range(65535, 65400) :
					(pick == 1) ? $urandom_range(65535, 0) : $urandom_range(200, 0);
				for (int j = 0; j < size; j++) begin
					if ($urandom_range(3, 0) != 0)
						arr = arr + $urandom_range(20, 0);
					if (arr > 65535)
						arr = 65535;
					pick = $urandom_range(3, 0);
					burst = (pick < 2) ? $urandom_range(15, 1) :
						(pick == 2) ? $urandom_range(200, 1) : $urandom_range(65535, 1);
					send_job(arr, burst, j == size - 1);
				end
				if ($urandom_range(3, 0) == 0)
					drop_start();
			end
		end
		start <= 0;

		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
design/srtf_pkg.sv
design/srtf_turnaround_evaluator.sv
design/srtf_chk.sv
test/tb_srtf_turnaround_evaluator.sv
